// ===== rtl/assert_macros.svh =====
// Assertion macros; the assertion forms compile away under NO_ASSERTIONS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)

`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ===== rtl/fbba_pkg.sv =====
package fbba_pkg;

	localparam int MAX_UNITS  = 4096;
	localparam int WORD_WIDTH = 32;
	localparam int NUM_WORDS  = (MAX_UNITS + WORD_WIDTH - 1) / WORD_WIDTH;
	localparam int WADDR_W    = $clog2(NUM_WORDS);
	localparam int BIT_W      = $clog2(WORD_WIDTH);
	// summary search: groups of WORD_WIDTH word flags
	localparam int NUM_GRP    = (NUM_WORDS + WORD_WIDTH - 1) / WORD_WIDTH;
	localparam int GSEL_W     = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
	localparam int IDX_W      = 12;
	localparam int CNT_W      = 13;

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_TEST  = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_FULL   = 2'd1;
	localparam logic [1:0] STAT_RANGE  = 2'd2;
	localparam logic [1:0] STAT_DOUBLE = 2'd3;

	typedef struct packed {
		logic [1:0]       action;
		logic [IDX_W-1:0] unit_index;
	} alloc_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] granted_index;
		logic             is_free;
	} alloc_rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GRP,
		S_SEL,
		S_RD,
		S_UPD
	} fbba_state_t;

	typedef struct packed {
		logic load;
		logic grp;
		logic sel;
		logic rd;
		logic upd;
	} fbba_cmd_t;

endpackage

// ===== rtl/free_block_bitmap_allocator.sv =====
// done is registered from the update state. Allocate: group and select (the summary
// search, two registered stages), read (registered, single-port word RAM), update.
// Free or test: read and update. A new request is taken in idle or in update.
// done is a one-cycle strobe; the receiver cannot stall it.
// Reset or a bit_count write clears the map at once via per-word valid flags (no sweep):
// units below the count are free. bit_count resets to 4096.
module free_block_bitmap_allocator import fbba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  alloc_req_t       req,
	output logic             done,
	output alloc_rsp_t       rsp,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	fbba_cmd_t cmd;

	fbba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (req.action),
		.busy   (busy),
		.cmd    (cmd)
	);

	fbba_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/fbba_ctrl.sv =====
module fbba_ctrl import fbba_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	output logic       busy,
	output fbba_cmd_t  cmd
);

	fbba_state_t state_q, state_d;
	logic        take;

	assign take = start && (state_q == S_IDLE || state_q == S_UPD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_GRP: state_d = S_SEL;
			S_SEL: state_d = S_RD;
			S_RD:  state_d = S_UPD;
			S_IDLE, S_UPD: begin
				if (take) begin
					state_d = (action == ACT_ALLOC) ? S_GRP : S_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// the update cycle only touches registered operands, so a new beat may load then
	always_comb begin
		busy     = 1'b1;
		cmd      = '0;
		cmd.load = take;
		case (state_q)
			S_IDLE: busy = 1'b0;
			S_GRP:  cmd.grp = 1'b1;
			S_SEL:  cmd.sel = 1'b1;
			S_RD:   cmd.rd = 1'b1;
			S_UPD: begin
				busy    = 1'b0;
				cmd.upd = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

endmodule

// ===== rtl/fbba_dp.sv =====
`include "assert_macros.svh"

module fbba_dp import fbba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  fbba_cmd_t        cmd,
	input  alloc_req_t       req,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output logic             done,
	output alloc_rsp_t       rsp
);

	logic [WORD_WIDTH-1:0] mem [NUM_WORDS];

	logic [CNT_W-1:0]      bit_count_q;
	logic [NUM_WORDS-1:0]  valid_q;
	logic [NUM_WORDS-1:0]  nonempty_q;
	logic [1:0]            act_q;
	logic [IDX_W-1:0]      idx_q;
	logic [WADDR_W-1:0]    addr_q;
	logic                  found_q;
	logic [NUM_GRP-1:0]    grp_hit_s1;
	logic [BIT_W-1:0]      grp_low_s1 [NUM_GRP];
	logic [WORD_WIDTH-1:0] rd_word_q;
	logic                  rd_valid_q;
	logic                  done_q;
	alloc_rsp_t            rsp_q;

	logic [CNT_W-1:0]      cnt;
	logic [WORD_WIDTH-1:0] cur_word;
	logic [WORD_WIDTH-1:0] new_word;
	logic                  we;
	alloc_rsp_t            res;
	logic                  in_range;
	logic                  bit_val;
	logic [BIT_W-1:0]      low_bit;
	logic [GSEL_W-1:0]     gsel;
	logic [NUM_WORDS-1:0]  cfg_nonempty;

	function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_WIDTH-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int i = WORD_WIDTH - 1; i >= 0; i--) begin
			if (v[i]) r = BIT_W'(i);
		end
		return r;
	endfunction

	// word contents right after a clear: a one for every unit below the count
	function automatic logic [WORD_WIDTH-1:0] clear_word(input logic [WADDR_W-1:0] w,
			input logic [CNT_W-1:0] c);
		logic [WORD_WIDTH-1:0] r;
		for (int b = 0; b < WORD_WIDTH; b++) begin
			r[b] = (CNT_W'({w, BIT_W'(b)}) < c);
		end
		return r;
	endfunction

	assign cnt = (bit_count_q > CNT_W'(MAX_UNITS)) ? CNT_W'(MAX_UNITS) : bit_count_q;

	always_comb begin
		for (int w = 0; w < NUM_WORDS; w++) begin
			cfg_nonempty[w] = (CNT_W'(w * WORD_WIDTH) < cfg_wdata);
		end
	end

	always_comb begin
		gsel = '0;
		for (int g = NUM_GRP - 1; g >= 0; g--) begin
			if (grp_hit_s1[g]) gsel = GSEL_W'(g);
		end
	end

	// update stage
	assign cur_word = rd_valid_q ? rd_word_q : clear_word(addr_q, cnt);
	assign in_range = (CNT_W'(idx_q) < cnt);
	assign bit_val  = cur_word[idx_q[BIT_W-1:0]];
	assign low_bit  = lowest_set(cur_word);

	always_comb begin
		res      = '0;
		new_word = cur_word;
		we       = 1'b0;
		case (act_q)
			ACT_ALLOC: begin
				if (found_q) begin
					new_word          = cur_word & ~(WORD_WIDTH'(1) << low_bit);
					we                = 1'b1;
					res.granted_index = IDX_W'({addr_q, low_bit});
				end else begin
					res.status = STAT_FULL;
				end
			end
			ACT_FREE: begin
				if (!in_range) begin
					res.status = STAT_RANGE;
				end else if (bit_val) begin
					res.status = STAT_DOUBLE;
				end else begin
					new_word = cur_word | (WORD_WIDTH'(1) << idx_q[BIT_W-1:0]);
					we       = 1'b1;
				end
			end
			ACT_TEST: begin
				if (!in_range) begin
					res.status = STAT_RANGE;
				end else begin
					res.is_free = bit_val;
				end
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_word_q <= mem[addr_q];
		end
		if (cmd.upd && we) begin
			mem[addr_q] <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= CNT_W'(MAX_UNITS);
			valid_q     <= '0;
			nonempty_q  <= '1;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.upd;
			if (cfg_we) begin
				bit_count_q <= cfg_wdata;
				valid_q     <= '0;
				nonempty_q  <= cfg_nonempty;
			end else if (cmd.upd && we) begin
				valid_q[addr_q]    <= 1'b1;
				nonempty_q[addr_q] <= |new_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= req.action;
			idx_q  <= req.unit_index;
			addr_q <= req.unit_index[BIT_W +: WADDR_W];
		end else if (cmd.sel) begin
			found_q <= |grp_hit_s1;
			addr_q  <= WADDR_W'({gsel, grp_low_s1[gsel]});
		end
		if (cmd.grp) begin
			for (int g = 0; g < NUM_GRP; g++) begin
				grp_hit_s1[g] <= |nonempty_q[g*WORD_WIDTH +: WORD_WIDTH];
				grp_low_s1[g] <= lowest_set(nonempty_q[g*WORD_WIDTH +: WORD_WIDTH]);
			end
		end
		if (cmd.rd) begin
			rd_valid_q <= valid_q[addr_q];
		end
		if (cmd.upd) begin
			rsp_q <= res;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`ASSERT_CLK(a_done_after_upd, done |-> $past(cmd.upd), "result beat without update cycle")
	`ASSERT_CLK(a_grant_in_range, done && |rsp.granted_index |-> CNT_W'(rsp.granted_index) < cnt, "grant over count")
	`ASSERT_CLK(a_cfg_clears, $past(cfg_we) |-> valid_q == '0, "config write left stale words")
	`ASSERT_CLK(a_summary_track, cmd.upd && we && !cfg_we |=> nonempty_q[$past(addr_q)] == $past(|new_word), "summary flag out of step")

endmodule

// ===== bench/tb_free_block_bitmap_allocator.sv =====
`timescale 1ns / 1ps

module tb_free_block_bitmap_allocator;
	import fbba_pkg::*;

	// action code the block treats as a no-op
	localparam logic [1:0] ACT_NONE = 2'd3;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic             busy;
	alloc_req_t       req       = '0;
	logic             done;
	alloc_rsp_t       rsp;
	logic             cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	// shadow of the allocator state
	logic [MAX_UNITS-1:0] free_bits;
	logic [CNT_W-1:0]     unit_count_m = 13'd4096;

	alloc_rsp_t       awaited_rsp[$];
	logic [IDX_W-1:0] held_units[$];
	int               send_idle_pct = 0;
	int               fault_count   = 0;

	free_block_bitmap_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("tb_free_block_bitmap_allocator: done, errors");
		$finish;
	end

	function automatic int live_units();
		return (unit_count_m > MAX_UNITS) ? MAX_UNITS : int'(unit_count_m);
	endfunction

	function automatic void reload_map();
		int lim;
		lim = live_units();
		for (int u = 0; u < MAX_UNITS; u++)
			free_bits[u] = (u < lim);
	endfunction

	// outcome of an allocate (first fit), free or test; updates the shadow map
	function automatic alloc_rsp_t alloc_outcome(alloc_req_t r);
		alloc_rsp_t o;
		int lim;
		o = '0;
		lim = live_units();
		case (r.action)
		ACT_ALLOC: begin
			o.status = STAT_FULL;
			for (int u = 0; u < lim; u++) begin
				if (free_bits[u]) begin
					free_bits[u]    = 1'b0;
					o.status        = STAT_OK;
					o.granted_index = u[IDX_W-1:0];
					break;
				end
			end
		end
		ACT_FREE, ACT_TEST: begin
			if (int'(r.unit_index) >= lim)
				o.status = STAT_RANGE;
			else if (r.action == ACT_TEST)
				o.is_free = free_bits[r.unit_index];
			else if (free_bits[r.unit_index])
				o.status = STAT_DOUBLE;
			else
				free_bits[r.unit_index] = 1'b1;
		end
		default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk) begin
		alloc_rsp_t want;
		if (arst_n && done) begin
			if (awaited_rsp.size() == 0) begin
				fault_count++;
				$display("%0t: unexpected beat, got status=%0d index=%0d free=%0b",
					$time, rsp.status, rsp.granted_index, rsp.is_free);
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.status !== want.status || rsp.granted_index !== want.granted_index ||
					rsp.is_free !== want.is_free) begin
					fault_count++;
					$display("%0t: mismatch, expected status=%0d index=%0d free=%0b, got status=%0d index=%0d free=%0b",
						$time, want.status, want.granted_index, want.is_free,
						rsp.status, rsp.granted_index, rsp.is_free);
				end
			end
		end
	end

	task automatic issue(input logic [1:0] act, input logic [IDX_W-1:0] idx);
		alloc_req_t r;
		alloc_rsp_t o;
		r.action     = act;
		r.unit_index = idx;
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		o = alloc_outcome(r);
		awaited_rsp.push_back(o);
		if (act == ACT_ALLOC && o.status == STAT_OK)
			held_units.push_back(o.granted_index);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (awaited_rsp.size() != 0 || busy);
	endtask

	task automatic write_unit_count(input logic [CNT_W-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we       <= 1'b0;
		unit_count_m = value;
		reload_map();
		held_units.delete();
	endtask

	function automatic logic [IDX_W-1:0] pick_index(input int lim);
		if (lim > 0 && $urandom_range(9) < 8)
			return IDX_W'($urandom_range(lim - 1));
		return IDX_W'($urandom());
	endfunction

	// map straight out of reset: everything free
	task automatic test_reset_map();
		issue(ACT_TEST, 12'd0);
		issue(ACT_TEST, 12'hFFF);
		issue(ACT_FREE, 12'd0);
		issue(ACT_ALLOC, 12'hFFF);
		issue(ACT_ALLOC, 12'd0);
		issue(ACT_TEST, 12'd0);
		issue(ACT_FREE, 12'd0);
		issue(ACT_NONE, 12'hFFF);
		issue(ACT_ALLOC, 12'hAAA);
	endtask

	task automatic test_single_unit();
		write_unit_count(13'd1);
		issue(ACT_ALLOC, 12'd0);
		issue(ACT_ALLOC, 12'd0);
		issue(ACT_TEST, 12'd1);
		issue(ACT_FREE, 12'd0);
		issue(ACT_TEST, 12'd0);
		issue(ACT_FREE, 12'hFFF);
	endtask

	task automatic test_zero_count();
		write_unit_count(13'd0);
		issue(ACT_ALLOC, 12'd0);
		issue(ACT_TEST, 12'd0);
		issue(ACT_FREE, 12'd0);
	endtask

	// counts above capacity clamp to the full map
	task automatic test_count_saturation();
		write_unit_count(13'h1FFF);
		issue(ACT_TEST, 12'hFFF);
		issue(ACT_FREE, 12'hFFF);
		issue(ACT_ALLOC, 12'h555);
	endtask

	task automatic test_random_traffic(input int n_items);
		int per_phase;
		int sel;
		int k;
		logic [IDX_W-1:0] u;
		logic [CNT_W-1:0] cnt;
		per_phase = n_items / 8;
		for (int p = 0; p < 8; p++) begin
			case (p)
			0: cnt = 13'd4096;
			1: cnt = 13'd24;
			2: cnt = 13'h1FFF;
			3: cnt = 13'd1;
			4: cnt = 13'd300;
			5: cnt = CNT_W'($urandom());
			6: cnt = 13'd33;
			default: cnt = 13'd0;
			endcase
			write_unit_count(cnt);
			case (p % 4)
			0: send_idle_pct = 0;
			1: send_idle_pct = 85;
			2: send_idle_pct = 16;
			default: send_idle_pct = 0;
			endcase
			for (int i = 0; i < per_phase; i++) begin
				// hold off until every outstanding beat is back
				if (i == per_phase / 2)
					wait_drained();
				sel = $urandom_range(99);
				if (sel < 45) begin
					issue(ACT_ALLOC, IDX_W'($urandom()));
				end else if (sel < 75 && held_units.size() != 0) begin
					k = $urandom_range(held_units.size() - 1);
					u = held_units[k];
					held_units.delete(k);
					issue(ACT_FREE, u);
				end else if (sel < 85) begin
					issue(ACT_FREE, pick_index(live_units()));
				end else if (sel < 96) begin
					issue(ACT_TEST, pick_index(live_units()));
				end else begin
					issue(ACT_NONE, IDX_W'($urandom()));
				end
			end
		end
		send_idle_pct = 0;
	endtask

	initial begin
		reload_map();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_map();
		test_single_unit();
		test_zero_count();
		test_count_saturation();
		test_random_traffic(1240);
		wait_drained();
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("tb_free_block_bitmap_allocator: done, clean");
		else
			$display("tb_free_block_bitmap_allocator: done, errors");
		$finish;
	end

endmodule
